@@ src/ksd_pkg.sv @@
// ----------------------------------------------------------------------------
// ksd_pkg
// shared types, widths and constants of the keypad scanner with debounce
// ----------------------------------------------------------------------------
package ksd_pkg;

  localparam int ROWS    = 4;
  localparam int COLUMNS = 3;

  localparam int LINE_W  = 3;
  localparam int DRIVE_W = 4;
  localparam int CODE_W  = 8;
  localparam int CNT_W   = 8;
  localparam int ROW_W   = 2;
  localparam int COL_W   = 2;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 8'h03;

  // ascii key codes, row by column
  localparam logic [CODE_W-1:0] KEY_TABLE [0:3][0:3] = '{
    '{8'h31, 8'h32, 8'h33, 8'h41},
    '{8'h34, 8'h35, 8'h36, 8'h42},
    '{8'h37, 8'h38, 8'h39, 8'h43},
    '{8'h2A, 8'h30, 8'h23, 8'h44}
  };

  typedef enum logic [3:0] {
    MODE_SCAN         = 4'b0001,
    MODE_WAIT_PRESS   = 4'b0010,
    MODE_RELEASE      = 4'b0100,
    MODE_WAIT_RELEASE = 4'b1000
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [ROW_W-1:0]  scan_row;
    logic [COL_W-1:0]  scan_column;
    logic [CNT_W-1:0]  debounce_count;
  } ksd_state_t;

  localparam ksd_state_t STATE_RESET = '{
    mode:           MODE_SCAN,
    scan_row:       '0,
    scan_column:    '0,
    debounce_count: '0
  };

  typedef struct packed {
    logic [DRIVE_W-1:0] row_drive;
    logic               key_valid;
    logic [CODE_W-1:0]  key_code;
  } ksd_result_t;

endpackage

@@ src/ksd_if.sv @@
// ----------------------------------------------------------------------------
// ksd_if
// valid/ready channels of the keypad scanner: column samples in, results out
// ----------------------------------------------------------------------------
interface ksd_in_if;
  import ksd_pkg::*;

  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] column_lines;

  modport source (output valid, output column_lines, input ready);
  modport sink   (input valid, input column_lines, output ready);
endinterface

interface ksd_out_if;
  import ksd_pkg::*;

  logic               valid;
  logic               ready;
  logic [DRIVE_W-1:0] row_drive;
  logic               key_valid;
  logic [CODE_W-1:0]  key_code;

  modport source (output valid, output row_drive, output key_valid, output key_code,
                  input ready);
  modport sink   (input valid, input row_drive, input key_valid, input key_code,
                  output ready);
endinterface

@@ src/ksd_step.sv @@
// ----------------------------------------------------------------------------
// ksd_step
// next state and result of the scanner for one column sample
// ----------------------------------------------------------------------------
module ksd_step (
  input  ksd_pkg::ksd_state_t               state_i,
  input  logic [ksd_pkg::LINE_W-1:0]        column_lines_i,
  input  logic [ksd_pkg::CNT_W-1:0]         debounce_limit_i,
  output ksd_pkg::ksd_state_t               state_o,
  output ksd_pkg::ksd_result_t              result_o
);
  import ksd_pkg::*;

  localparam int PAD_W = 1 << COL_W;

  logic [PAD_W-1:0] lines_pad;
  logic             all_high;
  logic             wait_done;
  logic [CNT_W-1:0] count_step;

  // columns without an input line read as released
  assign lines_pad = {{(PAD_W-LINE_W){1'b1}}, column_lines_i};
  assign all_high  = &lines_pad[COLUMNS-1:0];

  assign wait_done  = state_i.debounce_count > debounce_limit_i;
  assign count_step = wait_done ? '0 : state_i.debounce_count + CNT_W'(1);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    unique case (state_i.mode)
      MODE_SCAN: begin
        if (!lines_pad[state_i.scan_column]) begin
          result_o.key_valid = 1'b1;
          result_o.key_code  = KEY_TABLE[state_i.scan_row][state_i.scan_column];
          state_o.mode       = MODE_WAIT_PRESS;
        end else begin
          state_o.scan_row    = (state_i.scan_row >= ROW_W'(ROWS-1)) ? '0
                                : state_i.scan_row + ROW_W'(1);
          state_o.scan_column = (state_i.scan_column >= COL_W'(COLUMNS-1)) ? '0
                                : state_i.scan_column + COL_W'(1);
        end
      end
      MODE_WAIT_PRESS: begin
        state_o.debounce_count = count_step;
        if (wait_done) begin
          state_o.mode = MODE_RELEASE;
        end
      end
      MODE_RELEASE: begin
        if (all_high) begin
          state_o.mode = MODE_WAIT_RELEASE;
        end
      end
      MODE_WAIT_RELEASE: begin
        state_o.debounce_count = count_step;
        if (wait_done) begin
          state_o.mode = MODE_SCAN;
        end
      end
      default: begin
        state_o.mode = MODE_SCAN;
      end
    endcase

    if (state_o.mode == MODE_SCAN) begin
      result_o.row_drive = ~(DRIVE_W'(1) << state_o.scan_row);
    end else begin
      result_o.row_drive = '0;
    end
  end

endmodule

@@ src/keypad_scan_debounce.sv @@
// ----------------------------------------------------------------------------
// keypad_scan_debounce
// 4x3 matrix keypad scanner with press and release debounce
// ----------------------------------------------------------------------------
// One item is one timer tick carrying the column lines sampled under the row
// drive of the previous result; each item gives exactly one result with the
// next row drive and, on a press, the key's ascii code. The block takes an
// item in every cycle while the output is not stalled: a column sample is
// registered in in_cols_r, the mode logic is combinational and the result
// is registered in out_res_r. The debounce threshold resets to 3; the user
// must write it through cfg_we/cfg_wdata only while no item is in flight,
// and the block itself does not enforce this.
module keypad_scan_debounce (
  input  logic                       clk,
  input  logic                       rst_n,
  ksd_in_if.sink                     in_ch,
  ksd_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [ksd_pkg::CNT_W-1:0]  cfg_wdata
);
  import ksd_pkg::*;

  logic              in_valid_r;
  logic [LINE_W-1:0] in_cols_r;
  ksd_state_t        state_r;
  ksd_state_t        state_nxt;
  logic [CNT_W-1:0]  limit_r;
  logic              out_valid_r;
  ksd_result_t       out_res_r;
  ksd_result_t       res_nxt;
  logic              advance;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !in_valid_r || advance;

  ksd_step u_step (
    .state_i          (state_r),
    .column_lines_i   (in_cols_r),
    .debounce_limit_i (limit_r),
    .state_o          (state_nxt),
    .result_o         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
      limit_r     <= LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
        if (in_valid_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_cols_r <= in_ch.column_lines;
    end
    if (advance && in_valid_r) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_drive = out_res_r.row_drive;
  assign out_ch.key_valid = out_res_r.key_valid;
  assign out_ch.key_code  = out_res_r.key_code;

endmodule

@@ src/ksd_checker.sv @@
// ----------------------------------------------------------------------------
// ksd_checker
// port level checks of the keypad scanner, bound to the top level
// ----------------------------------------------------------------------------
module ksd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ksd_pkg::DRIVE_W-1:0]  row_drive,
  input logic                         key_valid,
  input logic [ksd_pkg::CODE_W-1:0]   key_code
);
  import ksd_pkg::*;

  // a press always moves on to the debounce wait with all rows driven
  a_press_drives_all: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && key_valid |-> row_drive == '0)
    else $error("row drive not all low on a key press");

  a_code_only_on_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !key_valid |-> key_code == '0)
    else $error("key code set without a key press");

  a_code_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && key_valid |-> key_code != '0)
    else $error("key press with empty code");

  // scanning drives exactly one row low
  a_scan_one_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && row_drive != '0 |-> $onehot(~row_drive))
    else $error("scan drive with more than one row low");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(row_drive)
      && $stable(key_valid) && $stable(key_code))
    else $error("stalled item changed");

endmodule

bind keypad_scan_debounce ksd_checker u_ksd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .row_drive (out_ch.row_drive),
  .key_valid (out_ch.key_valid),
  .key_code  (out_ch.key_code)
);
